// File: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/cric_pkg.sv
// ----------------------------------------------------------------------------
// cric_pkg
// shared types and constants of the can receive identifier cache
// ----------------------------------------------------------------------------
package cric_pkg;

  localparam int ID_W   = 11;
  localparam int DATA_W = 64;
  localparam int LEN_W  = 4;
  localparam int TIME_W = 32;

  localparam logic [LEN_W-1:0]  MAX_DLC       = 4'd8;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_READ  = 2'd1,
    OP_CHECK = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RD_DATA,
    ST_RD_TAKE,
    ST_CHK_SUB,
    ST_CHK_CMP,
    ST_RESP
  } state_t;

  // shared subtract / compare unit output
  typedef struct packed {
    logic [TIME_W-1:0] diff;
    logic              lt;
  } alu_res_t;

  // keep the low len bytes
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      m[b*8 +: 8] = (LEN_W'(b) < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// File: src/cric_alu.sv
// ----------------------------------------------------------------------------
// cric_alu
// shared 32-bit subtractor: difference and unsigned less-than
// ----------------------------------------------------------------------------
module cric_alu
  import cric_pkg::*;
(
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  output alu_res_t          res
);

  logic [TIME_W:0] wide;

  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.diff = wide[TIME_W-1:0];
  assign res.lt   = wide[TIME_W];

endmodule

// File: src/can_rx_id_cache.sv
// ----------------------------------------------------------------------------
// can_rx_id_cache
// slot table keyed by 11-bit can identifier: store, read-once and link check
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  in       | in_valid / in_ready | operation can_id is_extended is_remote
//           |                     | frame_len frame_bytes now_ms
//  out      | out_valid/out_ready | ok out_bytes out_len out_stamp
//  cfg      | cfg_wr_en           | cfg_wr_data (link_timeout_ms)
//
//  one request at a time; the identifier memory is scanned one slot per cycle,
//  and a request ends sooner when the scan hits early
//  dropped frames and unknown operations skip the scan
//  the result sits in an output register, so a new request is taken while
//  the previous result waits on out_ready
//  rst is synchronous; slot contents are not cleared, only used/unread bits
//
`include "assert_macros.svh"

module can_rx_id_cache
  import cric_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        operation,
  input  logic [ID_W-1:0]   can_id,
  input  logic              is_extended,
  input  logic              is_remote,
  input  logic [LEN_W-1:0]  frame_len,
  input  logic [DATA_W-1:0] frame_bytes,
  input  logic [TIME_W-1:0] now_ms,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ok,
  output logic [DATA_W-1:0] out_bytes,
  output logic [LEN_W-1:0]  out_len,
  output logic [TIME_W-1:0] out_stamp
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  state_t state, state_next;

  // configuration register
  logic [TIME_W-1:0] link_timeout_ms;

  // per-slot flags in flops
  logic [SLOT_COUNT-1:0] slot_used;
  logic [SLOT_COUNT-1:0] slot_unread;

  // slot memories
  logic [ID_W-1:0]   ident_mem [SLOT_COUNT];
  logic [TIME_W-1:0] seen_mem  [SLOT_COUNT];
  logic [DATA_W-1:0] bytes_mem [SLOT_COUNT];
  logic [LEN_W-1:0]  len_mem   [SLOT_COUNT];
  logic [TIME_W-1:0] stamp_mem [SLOT_COUNT];

  logic [ID_W-1:0]   ident_rd;
  logic [TIME_W-1:0] seen_rd;
  logic [DATA_W-1:0] bytes_rd;
  logic [LEN_W-1:0]  len_rd;
  logic [TIME_W-1:0] stamp_rd;

  // captured request
  op_t               op_q;
  logic [ID_W-1:0]   id_q;
  logic [LEN_W-1:0]  len_q;
  logic [DATA_W-1:0] bytes_q;
  logic [TIME_W-1:0] now_q;

  // scan sequencer
  logic [IDX_W-1:0]  rd_idx;
  logic              issue_done;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_valid;
  logic [IDX_W-1:0]  oldest_idx;
  logic [TIME_W-1:0] oldest_val;
  logic [IDX_W-1:0]  slot_q;
  logic              new_q;
  logic [TIME_W-1:0] seen_q;
  logic [TIME_W-1:0] elapsed_q;

  // pending result
  logic              res_ok;
  logic [DATA_W-1:0] res_bytes;
  logic [LEN_W-1:0]  res_len;
  logic [TIME_W-1:0] res_stamp;

  // shared compare unit
  logic [TIME_W-1:0] alu_a, alu_b;
  alu_res_t          alu_res;

  logic in_fire, out_load;
  logic cmp_used, cmp_match, cmp_last, oldest_take;
  logic len_ok, slot_write, req_drop;

  cric_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // operand select: oldest search during scan, then elapsed and timeout
  always_comb begin
    case (state)
      ST_CHK_SUB: begin
        alu_a = now_q;
        alu_b = seen_q;
      end
      ST_CHK_CMP: begin
        alu_a = elapsed_q;
        alu_b = link_timeout_ms;
      end
      default: begin
        alu_a = seen_rd;
        alu_b = oldest_val;
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == ST_RESP) && (!out_valid || out_ready);

  // dropped frames and unknown codes need no table access
  assign req_drop = ((op_t'(operation) == OP_STORE) && (is_extended || is_remote)) ||
                    ((op_t'(operation) != OP_STORE) && (op_t'(operation) != OP_READ) &&
                     (op_t'(operation) != OP_CHECK));

  assign cmp_used    = slot_used[cmp_idx];
  assign cmp_match   = cmp_used && (ident_rd == id_q);
  assign cmp_last    = (cmp_idx == LAST_IDX);
  assign oldest_take = (cmp_idx == '0) || alu_res.lt;

  assign len_ok     = (len_q <= MAX_DLC);
  assign slot_write = (state == ST_WRITE) && (new_q || len_ok);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = req_drop ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmp_valid) begin
          if (op_q == OP_STORE) begin
            if (cmp_match || !cmp_used || cmp_last) begin
              state_next = ST_WRITE;
            end
          end else if (cmp_match) begin
            if (op_q == OP_READ) begin
              state_next = slot_unread[cmp_idx] ? ST_RD_DATA : ST_RESP;
            end else begin
              state_next = ST_CHK_SUB;
            end
          end else if (cmp_last) begin
            state_next = ST_RESP;
          end
        end
      end
      ST_WRITE:   state_next = ST_RESP;
      ST_RD_DATA: state_next = ST_RD_TAKE;
      ST_RD_TAKE: state_next = ST_RESP;
      ST_CHK_SUB: state_next = ST_CHK_CMP;
      ST_CHK_CMP: state_next = ST_RESP;
      ST_RESP: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      link_timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      link_timeout_ms <= cfg_wr_data;
    end
  end

  // slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used   <= '0;
      slot_unread <= '0;
    end else if (state == ST_WRITE) begin
      if (new_q) begin
        slot_used[slot_q] <= 1'b1;
      end
      // a valid dlc marks the slot unread; a long dlc clears a new slot's mark and leaves a held slot's mark alone
      if (len_ok) begin
        slot_unread[slot_q] <= 1'b1;
      end else if (new_q) begin
        slot_unread[slot_q] <= 1'b0;
      end
    end else if (state == ST_RD_TAKE) begin
      slot_unread[slot_q] <= 1'b0;
    end
  end

  // identifier / last-seen memory, read by the scan counter
  always_ff @(posedge clk) begin
    if (slot_write) begin
      ident_mem[slot_q] <= id_q;
      seen_mem[slot_q]  <= now_q;
    end
    ident_rd <= ident_mem[rd_idx];
    seen_rd  <= seen_mem[rd_idx];
  end

  // frame memories, read at the chosen slot
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      bytes_mem[slot_q] <= len_ok ? (bytes_q & byte_mask(len_q)) : '0;
    end
    if (slot_write) begin
      len_mem[slot_q]   <= len_ok ? len_q : '0;
      stamp_mem[slot_q] <= len_ok ? now_q : '0;
    end
    bytes_rd <= bytes_mem[slot_q];
    len_rd   <= len_mem[slot_q];
    stamp_rd <= stamp_mem[slot_q];
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid  <= 1'b0;
      issue_done <= 1'b0;
      rd_idx     <= '0;
    end else if (in_fire) begin
      cmp_valid  <= 1'b0;
      issue_done <= 1'b0;
      rd_idx     <= '0;
    end else if (state == ST_SCAN) begin
      cmp_valid  <= !issue_done;
      issue_done <= issue_done || (rd_idx == LAST_IDX);
      if (!issue_done && (rd_idx != LAST_IDX)) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  // request capture, slot choice and result build
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      cmp_idx <= rd_idx;
    end
    if (in_fire) begin
      op_q      <= op_t'(operation);
      id_q      <= can_id;
      len_q     <= frame_len;
      bytes_q   <= frame_bytes;
      now_q     <= now_ms;
      res_ok    <= 1'b0;
      res_bytes <= '0;
      res_len   <= '0;
      res_stamp <= '0;
    end
    case (state)
      ST_SCAN: begin
        if (cmp_valid) begin
          if (op_q == OP_STORE) begin
            if (cmp_match) begin
              slot_q <= cmp_idx;
              new_q  <= 1'b0;
            end else if (!cmp_used) begin
              slot_q <= cmp_idx;
              new_q  <= 1'b1;
            end else begin
              // all slots so far are in use: track the oldest
              if (oldest_take) begin
                oldest_idx <= cmp_idx;
                oldest_val <= seen_rd;
              end
              slot_q <= oldest_take ? cmp_idx : oldest_idx;
              new_q  <= 1'b1;
            end
          end else if (cmp_match) begin
            slot_q <= cmp_idx;
            seen_q <= seen_rd;
          end
        end
      end
      ST_WRITE: begin
        res_ok <= len_ok;
      end
      ST_RD_TAKE: begin
        res_ok    <= 1'b1;
        res_bytes <= bytes_rd;
        res_len   <= len_rd;
        res_stamp <= stamp_rd;
      end
      ST_CHK_SUB: begin
        elapsed_q <= alu_res.diff;
      end
      ST_CHK_CMP: begin
        res_ok <= alu_res.lt;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ok        <= res_ok;
      out_bytes <= res_bytes;
      out_len   <= res_len;
      out_stamp <= res_stamp;
    end
  end

  // checks
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_NEXT(a_result_loaded, clk, rst, out_load, out_valid)
  `ASSERT_IMPLIES(a_unread_is_used, clk, rst, 1'b1, (slot_unread & ~slot_used) == '0)

endmodule
